### rtl/core/tlp_pkg.sv
// ----------------------------------------------------------------------------
// tlp_pkg
// Shared constants and types for the tally line parser: prefix text,
// terminator and tally characters, field widths and the result beat.
// ----------------------------------------------------------------------------
package tlp_pkg;

    localparam int MAX_CHANNELS = 32;
    localparam int CNT_W        = 6;
    localparam int WORD_W       = 64;
    localparam int LIMIT_W      = 6;
    localparam int POS_W        = 4;

    localparam logic [POS_W-1:0] TAG_LEN = POS_W'(9);

    localparam logic [7:0] PREFIX_TEXT [9] = '{
        8'h54, 8'h41, 8'h4C, 8'h4C, 8'h59, 8'h20, 8'h4F, 8'h4B, 8'h20
    };

    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_LF      = 8'h0A;
    localparam logic [7:0] CHR_PROGRAM = 8'h31;
    localparam logic [7:0] CHR_PREVIEW = 8'h32;

    localparam logic [1:0] TALLY_PROGRAM = 2'b01;
    localparam logic [1:0] TALLY_PREVIEW = 2'b10;
    localparam logic [1:0] TALLY_OFF     = 2'b00;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHANNELS);

    typedef struct packed {
        logic [WORD_W-1:0]  tally_word;
        logic [CNT_W-1:0]   chan_total;
        logic [LIMIT_W-1:0] shown_count;
        logic               changed;
    } t_result;

endpackage

### rtl/core/tally_line_parser.sv
// ----------------------------------------------------------------------------
// tally_line_parser
// Byte-stream parser that finds a "TALLY OK " line per chunk and reports
// the packed 2-bit tally word, channel counts and a change flag.
// ----------------------------------------------------------------------------
// One byte is taken every cycle unless the input is stalled. A byte is held
// in the input register, then the prefix matcher and bit setter update the
// parse state and, at a line end or a chunk end, load the result register:
// the byte that ends the line passes the input register and then the result
// register before the result beat is valid. Rate is set by the state update
// loop (prefix position, counter, word). The input stalls only while the
// result register is full and its beat is stalled.
module tally_line_parser
    import tlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_chunk_end,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [WORD_W-1:0]  o_tally_word,
    output logic [CNT_W-1:0]   o_chan_total,
    output logic [LIMIT_W-1:0] o_shown_count,
    output logic               o_changed
);

    logic [LIMIT_W-1:0] r_limit;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic               r_collecting, n_collecting;
    logic               r_chunk_done, n_chunk_done;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [WORD_W-1:0]  r_word,  n_word;
    logic [WORD_W-1:0]  r_stored, n_stored;

    logic               r_out_valid;
    t_result            r_out, n_out;

    logic               advance;
    logic               fire;
    logic               emit;
    logic [POS_W-1:0]   cur_pos;
    logic [POS_W-1:0]   next_pos;
    logic               is_term;
    logic [CNT_W-1:0]   add_cnt;
    logic [WORD_W-1:0]  add_word;
    logic [1:0]         tally_code;
    logic [CNT_W-1:0]   emit_cnt;
    logic [WORD_W-1:0]  emit_word;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_chunk_end;
        end
    end

    // prefix matcher; a mismatch on 'T' restarts the match at one
    always_comb begin
        cur_pos = (r_pos >= TAG_LEN) ? '0 : r_pos;
        if (r_in_byte == PREFIX_TEXT[cur_pos]) begin
            next_pos = cur_pos + POS_W'(1);
        end else if (r_in_byte == PREFIX_TEXT[0]) begin
            next_pos = POS_W'(1);
        end else begin
            next_pos = '0;
        end
    end

    // bit setter for one field character
    always_comb begin
        is_term = (r_in_byte == CHR_CR) || (r_in_byte == CHR_LF);
        priority if (r_in_byte == CHR_PROGRAM) begin
            tally_code = TALLY_PROGRAM;
        end else if (r_in_byte == CHR_PREVIEW) begin
            tally_code = TALLY_PREVIEW;
        end else begin
            tally_code = TALLY_OFF;
        end
        if (r_cnt < CNT_MAX) begin
            add_word = r_word | (WORD_W'(tally_code) << {r_cnt[4:0], 1'b0});
            add_cnt  = r_cnt + CNT_W'(1);
        end else begin
            add_word = r_word;
            add_cnt  = r_cnt;
        end
    end

    always_comb begin
        n_pos        = r_pos;
        n_collecting = r_collecting;
        n_chunk_done = r_chunk_done;
        n_cnt        = r_cnt;
        n_word       = r_word;
        n_stored     = r_stored;
        emit         = 1'b0;
        emit_cnt     = r_cnt;
        emit_word    = r_word;

        if (!r_chunk_done) begin
            if (r_collecting) begin
                if (is_term) begin
                    emit = 1'b1;
                end else begin
                    n_cnt     = add_cnt;
                    n_word    = add_word;
                    emit_cnt  = add_cnt;
                    emit_word = add_word;
                    emit      = r_in_last;
                end
            end else begin
                n_pos = next_pos;
                if (next_pos >= TAG_LEN) begin
                    n_pos        = '0;
                    n_collecting = 1'b1;
                    n_cnt        = '0;
                    n_word       = '0;
                    emit_cnt     = '0;
                    emit_word    = '0;
                    emit         = r_in_last;
                end
            end
        end

        n_out.tally_word    = emit_word;
        n_out.chan_total    = emit_cnt;
        n_out.shown_count   = (r_limit != '0 && emit_cnt > r_limit) ? r_limit : emit_cnt;
        n_out.changed       = (emit_word != r_stored);

        if (emit) begin
            n_stored     = emit_word;
            n_collecting = 1'b0;
            n_chunk_done = 1'b1;
        end

        // chunk end clears the line state after the byte is handled
        if (r_in_last) begin
            n_pos        = '0;
            n_collecting = 1'b0;
            n_chunk_done = 1'b0;
            n_cnt        = '0;
            n_word       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_collecting <= 1'b0;
            r_chunk_done <= 1'b0;
            r_cnt        <= '0;
            r_word       <= '0;
            r_stored     <= '0;
        end else if (fire) begin
            r_pos        <= n_pos;
            r_collecting <= n_collecting;
            r_chunk_done <= n_chunk_done;
            r_cnt        <= n_cnt;
            r_word       <= n_word;
            r_stored     <= n_stored;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tally_word    = r_out.tally_word;
    assign o_chan_total    = r_out.chan_total;
    assign o_shown_count   = r_out.shown_count;
    assign o_changed       = r_out.changed;

    a_done_not_collecting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_chunk_done && r_collecting))
        else $error("chunk done while still collecting");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("character count beyond channel limit");

    a_chunk_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> (!r_collecting && !r_chunk_done && r_pos == '0
                                 && r_cnt == '0 && r_word == '0))
        else $error("line state not cleared after chunk end beat");

    a_result_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && emit) |=> (r_stored == r_out.tally_word && r_out_valid))
        else $error("emitted word not stored");

endmodule
